// ----- hw/rtl/dtsm_pkg.sv -----
// Shared types and constants for the disk track/sector mapper.
// Depends on nothing; used by the channel interfaces and the top level.
package dtsm_pkg;

	localparam int NUM_SECTORS = 683;
	localparam int MAX_TRACK   = 35;
	localparam int MAX_SECTOR  = 20;

	// Speed zones: first track, base sector number, sectors per track
	localparam int Z1_TRACK = 18;
	localparam int Z2_TRACK = 25;
	localparam int Z3_TRACK = 31;
	localparam int Z0_BASE  = 0;
	localparam int Z1_BASE  = 357;
	localparam int Z2_BASE  = 490;
	localparam int Z3_BASE  = 598;
	localparam int Z0_SPT   = 21;
	localparam int Z1_SPT   = 19;
	localparam int Z2_SPT   = 18;
	localparam int Z3_SPT   = 17;

	// Visited map is stored as rows of 16 bits
	localparam int ROW_BITS = 16;
	localparam int BIT_W    = $clog2(ROW_BITS);
	localparam int NUM_ROWS = (NUM_SECTORS + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_W    = $clog2(NUM_ROWS);

	localparam int IDX_W = 10;
	localparam int OFS_W = 18;

	localparam logic CMD_MAP   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		ST_GRANTED = 2'd0,
		ST_INVALID = 2'd1,
		ST_VISITED = 2'd2,
		ST_CLEARED = 2'd3
	} status_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] track_num;
		logic [7:0] sector_num;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [IDX_W-1:0]   sector_index;
		logic [OFS_W-1:0]   byte_offset;
	} rsp_t;

endpackage

// ----- hw/rtl/dtsm_req_if.sv -----
// Request channel of the disk track/sector mapper: valid, ready and one item.
// Depends on dtsm_pkg.
interface dtsm_req_if;
	logic              valid;
	logic              ready;
	dtsm_pkg::req_t    data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/dtsm_rsp_if.sv -----
// Result channel of the disk track/sector mapper: valid, ready and one item.
// Depends on dtsm_pkg.
interface dtsm_rsp_if;
	logic              valid;
	logic              ready;
	dtsm_pkg::rsp_t    data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/disk_track_sector_mapper.sv -----
// Track/sector to linear sector and byte offset mapper with a visited-sector map.
// Depends on dtsm_pkg, dtsm_req_if and dtsm_rsp_if.
//
// One item is accepted per cycle when nothing holds off the input. Its result passes
// the input register, the map-read register and the result register. A result that
// waits on the output stalls the whole pipeline and holds off the input. The visited
// map lives in a 43 x 16 bit memory with one read and one write port and is updated
// read-modify-write, with a one-entry bypass for back-to-back requests to the same
// row. After reset, and after each clear command, the map is zeroed one row a cycle,
// and no item is accepted during that pass. A clear command also holds off new items
// from the moment it is accepted until its zeroing pass is done.
module disk_track_sector_mapper (
	input  logic          clk,
	input  logic          arst_n,
	dtsm_req_if.sink      req,
	dtsm_rsp_if.source    rsp
);

	localparam int IW = dtsm_pkg::IDX_W;
	localparam int RW = dtsm_pkg::ROW_W;
	localparam int BW = dtsm_pkg::BIT_W;
	localparam int RB = dtsm_pkg::ROW_BITS;

	// stage 1: input register
	logic          v_s1;
	logic          cmd_s1;
	logic [7:0]    track_num_s1;
	logic [7:0]    sector_num_s1;

	// stage 2: mapped index, map row read
	logic          v_s2;
	logic          cmd_s2;
	logic          ok_s2;
	logic [IW-1:0] idx_s2;

	// result register
	logic                 out_valid_q;
	dtsm_pkg::status_t    status_q;
	logic [IW-1:0]        sector_index_q;

	// map memory and its control
	logic [RB-1:0] mem [dtsm_pkg::NUM_ROWS];
	logic [RB-1:0] rd_q;
	logic          byp_valid_q;
	logic [RW-1:0] byp_row_q;
	logic [RB-1:0] byp_data_q;
	logic          clr_busy_q;
	logic [RW-1:0] clr_row_q;

	logic          adv;
	logic          accept;
	logic [IW-1:0] idx_calc;
	logic          ok_calc;
	logic [RW-1:0] row_s1;
	logic [RW-1:0] row_s2;
	logic [RB-1:0] cur_row;
	logic [RB-1:0] wr_row;
	logic          hit;
	logic          wr_en;
	dtsm_pkg::status_t st_calc;

	assign adv = !out_valid_q || rsp.ready;
	assign req.ready = adv && !clr_busy_q && !(v_s1 && cmd_s1 == dtsm_pkg::CMD_CLEAR)
		&& !(v_s2 && cmd_s2 == dtsm_pkg::CMD_CLEAR);
	assign accept = req.valid && req.ready;

	// linear sector number
	always_comb begin
		logic [7:0] trk;
		logic [7:0] sct;
		logic       in_range;
		trk = track_num_s1;
		sct = sector_num_s1;
		in_range = (trk >= 8'd1) && (trk <= 8'(dtsm_pkg::MAX_TRACK))
			&& (sct <= 8'(dtsm_pkg::MAX_SECTOR));
		if (trk < 8'(dtsm_pkg::Z1_TRACK)) begin
			idx_calc = 10'(dtsm_pkg::Z0_BASE) + 10'(trk - 8'd1) * 10'(dtsm_pkg::Z0_SPT)
				+ 10'(sct);
		end else if (trk < 8'(dtsm_pkg::Z2_TRACK)) begin
			idx_calc = 10'(dtsm_pkg::Z1_BASE)
				+ 10'(trk - 8'(dtsm_pkg::Z1_TRACK)) * 10'(dtsm_pkg::Z1_SPT) + 10'(sct);
		end else if (trk < 8'(dtsm_pkg::Z3_TRACK)) begin
			idx_calc = 10'(dtsm_pkg::Z2_BASE)
				+ 10'(trk - 8'(dtsm_pkg::Z2_TRACK)) * 10'(dtsm_pkg::Z2_SPT) + 10'(sct);
		end else begin
			idx_calc = 10'(dtsm_pkg::Z3_BASE)
				+ 10'(trk - 8'(dtsm_pkg::Z3_TRACK)) * 10'(dtsm_pkg::Z3_SPT) + 10'(sct);
		end
		ok_calc = in_range && (idx_calc < 10'(dtsm_pkg::NUM_SECTORS));
		row_s1 = ok_calc ? idx_calc[IW-1:BW] : '0;
	end

	// map check against the read row, with bypass of the last write
	always_comb begin
		row_s2  = idx_s2[IW-1:BW];
		cur_row = (byp_valid_q && byp_row_q == row_s2) ? byp_data_q : rd_q;
		hit     = cur_row[idx_s2[BW-1:0]];
		wr_row  = cur_row | (RB'(1) << idx_s2[BW-1:0]);
		if (cmd_s2 == dtsm_pkg::CMD_CLEAR) begin
			st_calc = dtsm_pkg::ST_CLEARED;
		end else if (!ok_s2) begin
			st_calc = dtsm_pkg::ST_INVALID;
		end else if (hit) begin
			st_calc = dtsm_pkg::ST_VISITED;
		end else begin
			st_calc = dtsm_pkg::ST_GRANTED;
		end
		wr_en = adv && v_s2 && (st_calc == dtsm_pkg::ST_GRANTED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			byp_valid_q <= 1'b0;
			clr_busy_q  <= 1'b1;
			clr_row_q   <= '0;
		end else begin
			if (adv) begin
				v_s1        <= accept;
				v_s2        <= v_s1;
				out_valid_q <= v_s2;
				byp_valid_q <= wr_en;
			end
			if (clr_busy_q) begin
				if (clr_row_q == RW'(dtsm_pkg::NUM_ROWS - 1)) begin
					clr_busy_q <= 1'b0;
				end
				clr_row_q <= clr_row_q + RW'(1);
			end else if (adv && v_s2 && cmd_s2 == dtsm_pkg::CMD_CLEAR) begin
				clr_busy_q <= 1'b1;
				clr_row_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1        <= req.data.cmd;
			track_num_s1  <= req.data.track_num;
			sector_num_s1 <= req.data.sector_num;
			cmd_s2        <= cmd_s1;
			ok_s2         <= ok_calc;
			idx_s2        <= idx_calc;
			byp_row_q     <= row_s2;
			byp_data_q    <= wr_row;
			status_q      <= st_calc;
			sector_index_q <= (st_calc == dtsm_pkg::ST_GRANTED) ? idx_s2 : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_row_q] <= '0;
		end else if (wr_en) begin
			mem[row_s2] <= wr_row;
		end
		if (adv) begin
			rd_q <= mem[row_s1];
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.data.status       = status_q;
	assign rsp.data.sector_index = sector_index_q;
	assign rsp.data.byte_offset  = {sector_index_q, 8'd0};

	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q && clr_row_q == RW'(dtsm_pkg::NUM_ROWS - 1) |=> !clr_busy_q)
		else $error("clear pass ran past the last map row");

	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !clr_busy_q)
		else $error("map write while clear pass is active");

	a_grant_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == dtsm_pkg::ST_GRANTED
		|-> sector_index_q < IW'(dtsm_pkg::NUM_SECTORS))
		else $error("granted sector index beyond image");

	a_refusal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != dtsm_pkg::ST_GRANTED |-> sector_index_q == '0)
		else $error("refused item carries a sector index");

	a_no_accept_behind_clear: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && cmd_s2 == dtsm_pkg::CMD_CLEAR |-> !accept)
		else $error("item accepted while a clear is in flight");

endmodule

// ----- bench/tb.sv -----
// Testbench for disk_track_sector_mapper: drives request items, predicts each result
// with its own track/sector mapping and visited map, and checks every result item.
// Depends on dtsm_pkg, dtsm_req_if, dtsm_rsp_if and the mapper RTL.
`timescale 1ns / 100ps

module tb;

	class mapper_checker;
		bit   visited [dtsm_pkg::NUM_SECTORS];
		dtsm_pkg::rsp_t pending_results [$];
		int   errors;
		int   n_req, n_grant, n_revisit, n_invalid, n_clear;

		task report(string msg);
			errors++;
			if (errors <= 30)
				$display("MISMATCH at %0t: %s", $time, msg);
		endtask

		function dtsm_pkg::rsp_t predict_mapping(dtsm_pkg::req_t rq);
			dtsm_pkg::rsp_t res;
			int unsigned trk;
			int unsigned sct;
			int unsigned lin;
			res = '0;
			trk = rq.track_num;
			sct = rq.sector_num;
			if (rq.cmd == dtsm_pkg::CMD_CLEAR) begin
				foreach (visited[i]) visited[i] = 1'b0;
				res.status = dtsm_pkg::ST_CLEARED;
				n_clear++;
				return res;
			end
			if (trk < 1 || trk > dtsm_pkg::MAX_TRACK || sct > dtsm_pkg::MAX_SECTOR) begin
				res.status = dtsm_pkg::ST_INVALID;
				n_invalid++;
				return res;
			end
			if (trk < dtsm_pkg::Z1_TRACK)
				lin = dtsm_pkg::Z0_BASE + (trk - 1) * dtsm_pkg::Z0_SPT + sct;
			else if (trk < dtsm_pkg::Z2_TRACK)
				lin = dtsm_pkg::Z1_BASE + (trk - dtsm_pkg::Z1_TRACK) * dtsm_pkg::Z1_SPT + sct;
			else if (trk < dtsm_pkg::Z3_TRACK)
				lin = dtsm_pkg::Z2_BASE + (trk - dtsm_pkg::Z2_TRACK) * dtsm_pkg::Z2_SPT + sct;
			else
				lin = dtsm_pkg::Z3_BASE + (trk - dtsm_pkg::Z3_TRACK) * dtsm_pkg::Z3_SPT + sct;
			if (lin >= dtsm_pkg::NUM_SECTORS) begin
				res.status = dtsm_pkg::ST_INVALID;
				n_invalid++;
			end else if (visited[lin]) begin
				res.status = dtsm_pkg::ST_VISITED;
				n_revisit++;
			end else begin
				visited[lin]     = 1'b1;
				res.status       = dtsm_pkg::ST_GRANTED;
				res.sector_index = lin[dtsm_pkg::IDX_W-1:0];
				res.byte_offset  = {lin[dtsm_pkg::IDX_W-1:0], 8'd0};
				n_grant++;
			end
			return res;
		endfunction

		task note_request(dtsm_pkg::req_t rq);
			n_req++;
			pending_results.push_back(predict_mapping(rq));
		endtask

		task check_result(dtsm_pkg::rsp_t got);
			dtsm_pkg::rsp_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result item %p", got));
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.sector_index !== want.sector_index)
				report($sformatf("sector_index %0d, expected %0d",
					got.sector_index, want.sector_index));
			if (got.byte_offset !== want.byte_offset)
				report($sformatf("byte_offset %0d, expected %0d",
					got.byte_offset, want.byte_offset));
		endtask

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	dtsm_req_if req ();
	dtsm_rsp_if rsp ();

	disk_track_sector_mapper dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	mapper_checker chk = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left     = 0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				chk.note_request(req.data);
			if (rsp.valid && rsp.ready)
				chk.check_result(rsp.data);
		end
	end

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic dtsm_pkg::req_t mk(logic c, logic [7:0] t, logic [7:0] s);
		dtsm_pkg::req_t rq;
		rq.cmd        = c;
		rq.track_num  = t;
		rq.sector_num = s;
		return rq;
	endfunction

	function automatic dtsm_pkg::req_t random_request();
		int          r;
		int unsigned trk;
		int unsigned spt;
		r = $urandom_range(99);
		if (r < 3)
			return mk(dtsm_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom));
		if (r < 13)
			return mk(dtsm_pkg::CMD_MAP, 8'($urandom), 8'($urandom));
		trk = $urandom_range(dtsm_pkg::MAX_TRACK, 1);
		if (trk < dtsm_pkg::Z1_TRACK)
			spt = dtsm_pkg::Z0_SPT;
		else if (trk < dtsm_pkg::Z2_TRACK)
			spt = dtsm_pkg::Z1_SPT;
		else if (trk < dtsm_pkg::Z3_TRACK)
			spt = dtsm_pkg::Z2_SPT;
		else
			spt = dtsm_pkg::Z3_SPT;
		if ($urandom_range(99) < 85)
			return mk(dtsm_pkg::CMD_MAP, 8'(trk), 8'($urandom_range(spt - 1)));
		return mk(dtsm_pkg::CMD_MAP, 8'(trk), 8'($urandom_range(dtsm_pkg::MAX_SECTOR)));
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(dtsm_pkg::req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= item;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		@(negedge clk);
		while (chk.outstanding() != 0)
			@(negedge clk);
	endtask

	task automatic send_random(int count);
		repeat (count) send_item(random_request());
	endtask

	initial begin
		int saved_pct;
		arst_n    = 1'b0;
		req.valid = 1'b0;
		req.data  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zone edges, aliasing, refusals, revisits, clears
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd1, 8'd0));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd1, 8'd0));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd0, 8'd0));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd36, 8'd0));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd255, 8'd255));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd1, 8'd255));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd17, 8'd21));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd35, 8'd16));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd35, 8'd17));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd35, 8'd20));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd17, 8'd20));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd18, 8'd0));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd24, 8'd20));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd25, 8'd1));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd30, 8'd17));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd31, 8'd0));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd18, 8'd0));
		send_item(mk(dtsm_pkg::CMD_CLEAR, 8'd255, 8'd255));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd1, 8'd0));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd35, 8'd16));
		send_item(mk(dtsm_pkg::CMD_CLEAR, 8'd0, 8'd0));
		send_item(mk(dtsm_pkg::CMD_MAP, 8'd35, 8'd16));
		wait_drained();

		send_idle_pct = 34;
		recv_idle_pct = 48;
		send_random(60);
		// long result stall while requests keep coming
		saved_pct     = send_idle_pct;
		send_idle_pct = 0;
		hold_left     = 200;
		send_random(30);
		send_idle_pct = saved_pct;
		send_random(90);
		wait_drained();

		send_idle_pct = 48;
		recv_idle_pct = 34;
		send_random(180);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(90);
		wait_drained();
		send_random(90);

		req.valid <= 1'b0;
		while (chk.outstanding() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d requests: %0d granted, %0d revisits, %0d refused, %0d clears.",
			chk.n_req, chk.n_grant, chk.n_revisit, chk.n_invalid, chk.n_clear);
		$display("Idle mixes 34/48, 48/34 and none, a 200-cycle result stall, drain pauses.");
		if (chk.errors == 0 && chk.outstanding() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
